// ----- rtl/core/pms_pkg.sv -----
// shared types and constants of the partitioned multi-stack block
// no dependencies; used by pms_ctrl, pms_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

  // field widths fixed by the interface
  localparam int NS_W    = 6;
  localparam int IDX_W   = 5;
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 1;
  localparam int STAT_W  = 2;

  // longest display run and the width of its counter
  localparam int RUN_LIMIT = 32;
  localparam int RUN_W     = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH    = 1'b0;
  localparam logic [CMD_W-1:0] CMD_DISPLAY = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic div_step;
    logic look;
    logic exec;
    logic rd;
    logic send_single;
    logic send_elem;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_last;
    logic run;
    logic out_free;
    logic elem_last;
  } ctl_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/pms_ctrl.sv -----
// sequencing state machine of the partitioned multi-stack block
// depends on pms_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module pms_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             cfg_we,
  input  wire pms_pkg::ctl_stat_t stat,
  output pms_pkg::ctl_cmd_t     cmd,
  output logic                  in_stall
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DIV    = 7'b0000010,
    S_LOOK   = 7'b0000100,
    S_EXEC   = 7'b0001000,
    S_SINGLE = 7'b0010000,
    S_RD     = 7'b0100000,
    S_ELEM   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // input is taken only when idle and no register write is under way
  assign in_stall = (state != S_IDLE) || cfg_we;

  // next state and commands
  always_comb begin
    state_next      = state;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (cfg_we) begin
          state_next = S_DIV;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_IDLE;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.run ? S_RD : S_SINGLE;
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          cmd.send_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_ELEM;
      end
      S_ELEM: begin
        if (stat.out_free) begin
          cmd.send_elem = 1'b1;
          state_next    = stat.elem_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pms_datapath.sv -----
// datapath of the partitioned multi-stack block: stack count register,
// region divider, fill counts, slot memory and output register; uses pms_pkg
`timescale 1ns / 1ps
`default_nettype none

module pms_datapath #(
  parameter int TOTAL_SLOTS = 32,
  parameter int MAX_STACKS  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pms_pkg::NS_W-1:0]       cfg_wdata,
  input  wire logic [pms_pkg::CMD_W-1:0]      command,
  input  wire logic [pms_pkg::IDX_W-1:0]      stack_index,
  input  wire logic signed [pms_pkg::DATA_W-1:0] push_value,
  input  wire logic                           out_stall,
  input  wire pms_pkg::ctl_cmd_t              cmd,
  output pms_pkg::ctl_stat_t                  stat,
  output logic                                out_valid,
  output logic [pms_pkg::STAT_W-1:0]          status,
  output logic signed [pms_pkg::DATA_W-1:0]   element_value,
  output logic                                element_valid,
  output logic                                last_of_run
);

  localparam int AW  = $clog2(TOTAL_SLOTS);
  localparam int TW  = $clog2(TOTAL_SLOTS + 1);
  localparam int DCW = $clog2(TW);
  localparam int LIM = (MAX_STACKS < TOTAL_SLOTS) ? MAX_STACKS : TOTAL_SLOTS;
  localparam int FILL_DEPTH = (MAX_STACKS < 32) ? MAX_STACKS : 32;
  localparam int FIW = (FILL_DEPTH > 1) ? $clog2(FILL_DEPTH) : 1;
  localparam int SUM_W = ((TW > pms_pkg::RUN_W) ? TW : pms_pkg::RUN_W) + 1;
  localparam int PROD_W = TW + pms_pkg::IDX_W;
  localparam logic [TW-1:0] TOTAL_C = TW'(TOTAL_SLOTS);
  localparam logic [DCW-1:0] DIV_LAST_C = DCW'(TW - 1);
  localparam logic [pms_pkg::RUN_W-1:0] RUN_LIMIT_C = pms_pkg::RUN_W'(pms_pkg::RUN_LIMIT);

  // stack count and region divider (quotient register holds the region size)
  logic [pms_pkg::NS_W-1:0] ns;
  logic [pms_pkg::NS_W-1:0] ns_next;
  logic [TW-1:0]            div_q;
  logic [pms_pkg::NS_W-1:0] div_rem;
  logic [DCW-1:0]           div_cnt;
  logic [pms_pkg::NS_W:0]   div_trial;

  // latched request and lookup results
  logic [pms_pkg::CMD_W-1:0]  cmd_r;
  logic [pms_pkg::IDX_W-1:0]  idx_r;
  logic [pms_pkg::DATA_W-1:0] val_r;
  logic                       bad_r;
  logic                       last_stack_r;
  logic [AW-1:0]              base_r;
  logic [TW-1:0]              fill_r;
  pms_pkg::status_t           res_status;

  // fill counts and slot memory
  logic [TW-1:0]              fill_regs [FILL_DEPTH];
  logic [pms_pkg::DATA_W-1:0] slot_mem [TOTAL_SLOTS];
  logic [pms_pkg::DATA_W-1:0] rd_data;

  // display run counters
  logic [pms_pkg::RUN_W-1:0] elem_i;
  logic [pms_pkg::RUN_W-1:0] elem_cnt;

  // combinational helpers
  logic [PROD_W-1:0] prod;
  logic              idx_in_fill;
  logic [TW-1:0]     fill_cur;
  logic [TW-1:0]     cap;
  logic              full;
  logic              run;
  logic [SUM_W-1:0]  wr_sum;
  logic [SUM_W-1:0]  rd_sum;
  logic              out_free;

  // clamp of the written stack count
  always_comb begin
    priority if (cfg_wdata == '0) begin
      ns_next = pms_pkg::NS_W'(1);
    end else if (int'(cfg_wdata) > LIM) begin
      ns_next = pms_pkg::NS_W'(LIM);
    end else begin
      ns_next = cfg_wdata;
    end
  end

  // one restoring division step per cycle
  assign div_trial = {div_rem, div_q[TW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ns      <= pms_pkg::NS_W'(1);
      div_q   <= TOTAL_C;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cfg_we) begin
      ns      <= ns_next;
      div_q   <= TOTAL_C;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DCW'(1);
      if (div_trial >= {1'b0, ns}) begin
        div_rem <= pms_pkg::NS_W'(div_trial - {1'b0, ns});
        div_q   <= {div_q[TW-2:0], 1'b1};
      end else begin
        div_rem <= div_trial[pms_pkg::NS_W-1:0];
        div_q   <= {div_q[TW-2:0], 1'b0};
      end
    end
  end

  // request capture on input transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= command;
      idx_r <= stack_index;
      val_r <= push_value;
    end
  end

  // region base, index check and fill lookup
  assign prod        = {{pms_pkg::IDX_W{1'b0}}, div_q} * {{TW{1'b0}}, idx_r};
  assign idx_in_fill = int'(idx_r) < FILL_DEPTH;
  assign fill_cur    = idx_in_fill ? fill_regs[idx_r[FIW-1:0]] : '0;

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      base_r       <= prod[AW-1:0];
      bad_r        <= ({1'b0, idx_r} >= ns) || !idx_in_fill;
      last_stack_r <= ({1'b0, idx_r} == (ns - pms_pkg::NS_W'(1)));
      fill_r       <= fill_cur;
    end
  end

  // capacity and outcome of the request
  assign cap    = last_stack_r ? (TOTAL_C - TW'(base_r)) : div_q;
  assign full   = fill_r >= cap;
  assign run    = !bad_r && (cmd_r == pms_pkg::CMD_DISPLAY) && (fill_r != '0);
  assign wr_sum = SUM_W'(base_r) + SUM_W'(fill_r);
  assign rd_sum = SUM_W'(base_r) + SUM_W'(elem_i);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      priority if (bad_r) begin
        res_status <= pms_pkg::ST_BAD_INDEX;
      end else if (cmd_r == pms_pkg::CMD_PUSH) begin
        res_status <= full ? pms_pkg::ST_FULL : pms_pkg::ST_OK;
      end else if (fill_r == '0) begin
        res_status <= pms_pkg::ST_EMPTY;
      end else begin
        res_status <= pms_pkg::ST_OK;
      end
      elem_i   <= '0;
      elem_cnt <= (SUM_W'(fill_r) > SUM_W'(RUN_LIMIT_C)) ? RUN_LIMIT_C :
                  pms_pkg::RUN_W'(fill_r);
    end else if (cmd.send_elem) begin
      elem_i <= elem_i + pms_pkg::RUN_W'(1);
    end
  end

  // fill counts, cleared by reset and by any stack count write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int k = 0; k < FILL_DEPTH; k++) begin
        fill_regs[k] <= '0;
      end
    end else if (cmd.exec && !bad_r && (cmd_r == pms_pkg::CMD_PUSH) && !full) begin
      fill_regs[idx_r[FIW-1:0]] <= fill_r + TW'(1);
    end
  end

  // slot memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && !bad_r && (cmd_r == pms_pkg::CMD_PUSH) && !full) begin
      slot_mem[wr_sum[AW-1:0]] <= val_r;
    end
    if (cmd.rd) begin
      rd_data <= slot_mem[rd_sum[AW-1:0]];
    end
  end

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.send_single || cmd.send_elem) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send_single) begin
      status        <= res_status;
      element_value <= '0;
      element_valid <= 1'b0;
      last_of_run   <= 1'b1;
    end else if (cmd.send_elem) begin
      status        <= pms_pkg::ST_OK;
      element_value <= rd_data;
      element_valid <= 1'b1;
      last_of_run   <= stat.elem_last;
    end
  end

  // status back to the controller
  assign stat.div_last  = div_cnt == DIV_LAST_C;
  assign stat.run       = run;
  assign stat.out_free  = out_free;
  assign stat.elem_last = (elem_i + pms_pkg::RUN_W'(1)) == elem_cnt;

endmodule

`default_nettype wire

// ----- rtl/core/partitioned_multi_stack_top.sv -----
// Several stacks sharing one slot store.
// Input channel (in_valid / in_stall): command, stack_index, push_value.
// Output channel (out_valid / out_stall): status, element_value,
// element_valid, last_of_run. A transfer happens when valid is high and
// stall is low. One item is worked on at a time.
// A push gives one result; it passes the lookup, execute and output load
// states before the next input is taken, and its result is offered from
// the output register. A display of n elements gives n results, each a
// slot read then an output load, after lookup and execute; an empty stack
// or a bad index gives one result. The pace is set by the single-port
// slot memory and the fill count read-modify-write.
// Writing num_stacks (cfg_we / cfg_wdata) empties all stacks and then
// recomputes the region size in a bit-serial divider, one quotient bit a
// cycle with in_stall high.
// Reset leaves one stack, all stacks empty, output empty.
// While out_stall is high the result is held in the output register and
// the block waits before producing the next one.
// Pulls in pms_pkg, pms_ctrl and pms_datapath.
`timescale 1ns / 1ps
`default_nettype none

module partitioned_multi_stack_top #(
  parameter int TOTAL_SLOTS = 32,
  parameter int MAX_STACKS  = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pms_pkg::NS_W-1:0]          cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [pms_pkg::CMD_W-1:0]         command,
  input  wire logic [pms_pkg::IDX_W-1:0]         stack_index,
  input  wire logic signed [pms_pkg::DATA_W-1:0] push_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [pms_pkg::STAT_W-1:0]             status,
  output logic signed [pms_pkg::DATA_W-1:0]      element_value,
  output logic                                   element_valid,
  output logic                                   last_of_run
);

  pms_pkg::ctl_cmd_t  cmd;
  pms_pkg::ctl_stat_t stat;

  // sequencer
  pms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cfg_we   (cfg_we),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // storage and arithmetic
  pms_datapath #(
    .TOTAL_SLOTS (TOTAL_SLOTS),
    .MAX_STACKS  (MAX_STACKS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .command       (command),
    .stack_index   (stack_index),
    .push_value    (push_value),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .status        (status),
    .element_value (element_value),
    .element_valid (element_valid),
    .last_of_run   (last_of_run)
  );

endmodule

`default_nettype wire
